### hw/rtl/edm_pkg.sv
// Shared types, constants and helpers for the Euclidean distance map block.
// Used by the top level, controller and datapath under hw/rtl; depends on nothing else.
package edm_pkg;

   // Frame limits follow from the 8-bit read coordinates of the request.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int XW         = 8;
   localparam int YW         = 8;
   localparam int DIM_W      = 9;
   localparam int DELTA_W    = 9;
   localparam int DIST_W     = 17;
   localparam int MAP_AW     = XW + YW;
   localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int OUT_W      = 16;

   localparam int DEF_QUEUE_DEPTH     = 262144;
   localparam int DEF_PRECISION_SHIFT = 3;

   localparam logic [DIST_W-1:0] DIST_UNREACHED = 17'h1FFFF;
   localparam logic [OUT_W-1:0]  OUT_MAX        = 16'hFFFF;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_THRESHOLD = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic          op;
      logic [7:0]    luminance;
      logic          last_pixel;
      logic [XW-1:0] read_x;
      logic [YW-1:0] read_y;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] distance;
      logic             done_res;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [XW-1:0]             x;
      logic [YW-1:0]             y;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } qentry_type;

   localparam int QENTRY_W = $bits(qentry_type);

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_LOAD,
      DP_FILL,
      DP_PROP_BEGIN,
      DP_POP,
      DP_ENTRY,
      DP_NB_RD,
      DP_NB_SKIP,
      DP_NB_CMP,
      DP_FIN_RD,
      DP_SQRT_LOAD,
      DP_FIN_SAT,
      DP_FIN_WR,
      DP_RD_ISSUE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      respond;
   } dp_cmd_type;

   typedef struct packed {
      logic req_last;
      logic pos_in_frame;
      logic queue_empty;
      logic nb_inside;
      logic dir_last;
      logic cell_last;
      logic unreached;
      logic sqrt_done;
   } dp_status_type;

   // A zero size acts as one; larger sizes saturate at the maximum.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hw/rtl/euclidean_distance_map_top.sv
// Top level of the Euclidean distance map block.
// Depends on edm_pkg, edm_ctrl and edm_datapath.
//
// A load request steps through accept and write, a read through accept,
// memory read and result; each result shows on rsp_valid for one cycle in the
// cycle after the work ends, and the receiver cannot hold it off. A load
// marked last_pixel keeps busy high while the frame is computed: each cell not
// loaded in a short frame is filled, each queue entry is popped and fetched,
// then four neighbors are tried, those inside the frame taking a read and a
// compare state since the distance map has one port, then each frame cell is
// read and checked, and saturated if unreached or else passed through the
// bit-serial square root. The distance map has no reset; every cell of the
// frame is written before it is read.
module euclidean_distance_map_top
   import edm_pkg::*;
#(
   parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
   parameter int PRECISION_SHIFT = DEF_PRECISION_SHIFT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   edm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_read (req_item.op == OP_READ),
      .busy        (busy),
      .cmd         (cmd),
      .status      (status)
   );

   edm_datapath #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .PRECISION_SHIFT (PRECISION_SHIFT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### hw/rtl/edm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module edm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hw/rtl/edm_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
// Depends on nothing; used by the datapath for the final scaling pass.
module edm_isqrt #(
   parameter int IN_W = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [IN_W-1:0]     operand,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);

   localparam int RT_W  = IN_W / 2;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [IN_W-1:0]  opnd_ff, opnd_in;
   logic [RT_W:0]    rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RT_W+2:0]  rem_shift;
   logic [RT_W+2:0]  trial;

   always_comb begin
      rem_shift = {rem_ff, opnd_ff[IN_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      opnd_in   = opnd_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         opnd_in = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RT_W);
      end else if (cnt_ff != '0) begin
         opnd_in = opnd_ff << 2;
         cnt_in  = cnt_ff - 1'b1;
         if (rem_shift >= trial) begin
            rem_in  = (RT_W+1)'(rem_shift - trial);
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = (RT_W+1)'(rem_shift);
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = (cnt_ff == '0);
   assign root = root_ff;

endmodule

### hw/rtl/edm_ctrl.sv
// Controller state machine: sequences load, fill, propagation, scaling
// and read-back. Depends on edm_pkg.
module edm_ctrl
   import edm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_is_read,
   output logic          busy,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FILL,
      ST_POP,
      ST_ENTRY,
      ST_NB_RD,
      ST_NB_CMP,
      ST_FIN_RD,
      ST_FIN_CHK,
      ST_SQRT,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = DP_NOP;
      cmd.respond = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = DP_CAPTURE;
               state_in = req_is_read ? ST_RD_ISSUE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op = DP_LOAD;
            if (status.req_last) begin
               state_in = ST_FILL;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_FILL: begin
            // Cells never loaded in a short frame are set to unreached.
            if (status.pos_in_frame) begin
               cmd.op = DP_FILL;
            end else begin
               cmd.op   = DP_PROP_BEGIN;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (status.queue_empty) begin
               state_in = ST_FIN_RD;
            end else begin
               cmd.op   = DP_POP;
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            cmd.op   = DP_ENTRY;
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (status.nb_inside) begin
               cmd.op   = DP_NB_RD;
               state_in = ST_NB_CMP;
            end else begin
               cmd.op   = DP_NB_SKIP;
               state_in = status.dir_last ? ST_POP : ST_NB_RD;
            end
         end
         ST_NB_CMP: begin
            cmd.op   = DP_NB_CMP;
            state_in = status.dir_last ? ST_POP : ST_NB_RD;
         end
         ST_FIN_RD: begin
            cmd.op   = DP_FIN_RD;
            state_in = ST_FIN_CHK;
         end
         ST_FIN_CHK: begin
            if (status.unreached) begin
               cmd.op = DP_FIN_SAT;
               if (status.cell_last) begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_FIN_RD;
               end
            end else begin
               cmd.op   = DP_SQRT_LOAD;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.op = DP_FIN_WR;
               if (status.cell_last) begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_FIN_RD;
               end
            end
         end
         ST_RD_ISSUE: begin
            cmd.op   = DP_RD_ISSUE;
            state_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### hw/rtl/edm_datapath.sv
// Datapath: configuration registers, distance map, propagation queue,
// neighbor arithmetic, square root unit and result register.
// Depends on edm_pkg, edm_ram and edm_isqrt.
module edm_datapath
   import edm_pkg::*;
#(
   parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
   parameter int PRECISION_SHIFT = DEF_PRECISION_SHIFT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output logic                 rsp_valid,
   output rsp_type              rsp_item
);

   localparam int QA_W     = $clog2(QUEUE_DEPTH);
   localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SQ_RAW_W = DIST_W + 2 * PRECISION_SHIFT;
   localparam int SQ_IN_W  = SQ_RAW_W + (SQ_RAW_W % 2);
   localparam int RT_W     = SQ_IN_W / 2;
   localparam int NB_W     = XW + 2;
   localparam int SQ_W     = 2 * NB_W;
   localparam int VAL_W    = SQ_W + 1;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

   logic [DIM_W-1:0] img_w_ff, img_h_ff, thr_ff;
   logic [DIM_W-1:0] frame_w_ff, frame_w_in, frame_h_ff, frame_h_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [DIM_W-1:0] y_ff, y_in;
   logic [QA_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [QC_W-1:0]  count_ff, count_in;
   logic             done_ff, done_in, ovf_ff, ovf_in;
   req_type          req_ff;
   qentry_type       ent_ff;
   logic [1:0]       dir_ff, dir_in;
   logic [XW-1:0]    nx_ff;
   logic [YW-1:0]    ny_ff;
   logic signed [NB_W-1:0] ndx_ff, ndy_ff;
   logic signed [SQ_W-1:0] sqx_ff, sqy_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   logic [MAP_AW-1:0] map_addr;
   logic              map_we;
   logic [DIST_W-1:0] map_wdata, map_rdata;
   logic              q_we;
   qentry_type        q_wentry;
   logic [QENTRY_W-1:0] q_rdata;

   logic             pos0, in_frame, seed, x_last, cell_last, improves;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic             push_req, push_ok;
   logic [QC_W-1:0]  count_base;
   logic [QA_W-1:0]  tail_base;
   logic signed [NB_W-1:0] sx, sy, nx_c, ny_c, ndx_c, ndy_c;
   logic             nb_inside;
   logic [VAL_W-1:0] val;
   logic             sq_done;
   logic [RT_W-1:0]  sq_root;
   logic             read_inside;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= DIM_W'(256);
         img_h_ff <= DIM_W'(256);
         thr_ff   <= DIM_W'(128);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            CSR_FG_THRESHOLD: thr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Neighbor offsets in the order left, up, right, down.
   always_comb begin
      sx = '0;
      sy = '0;
      case (dir_ff)
         DIR_LEFT:  sx = -NB_W'(1);
         DIR_UP:    sy = -NB_W'(1);
         DIR_RIGHT: sx = NB_W'(1);
         DIR_DOWN:  sy = NB_W'(1);
         default: ;
      endcase
   end

   assign nx_c  = $signed({2'b00, ent_ff.x}) + sx;
   assign ny_c  = $signed({2'b00, ent_ff.y}) + sy;
   assign ndx_c = NB_W'(ent_ff.dx) + sx;
   assign ndy_c = NB_W'(ent_ff.dy) + sy;
   assign nb_inside = !nx_c[NB_W-1] && !ny_c[NB_W-1]
                      && (nx_c < $signed({1'b0, frame_w_ff}))
                      && (ny_c < $signed({1'b0, frame_h_ff}));

   assign val      = VAL_W'($unsigned(sqx_ff)) + VAL_W'($unsigned(sqy_ff));
   assign improves = (val < VAL_W'(map_rdata));

   assign pos0     = (x_ff == '0) && (y_ff == '0);
   assign eff_w    = pos0 ? clamp_dim(img_w_ff, MAX_W_DIM) : frame_w_ff;
   assign eff_h    = pos0 ? clamp_dim(img_h_ff, MAX_H_DIM) : frame_h_ff;
   assign in_frame = (y_ff < eff_h);
   assign seed     = ({1'b0, req_ff.luminance} < thr_ff);
   assign x_last   = ({1'b0, x_ff} == eff_w - 1'b1);
   assign cell_last = ({1'b0, x_ff} == frame_w_ff - 1'b1)
                      && (y_ff == frame_h_ff - 1'b1);

   assign read_inside = ({1'b0, req_ff.read_x} < frame_w_ff)
                        && ({1'b0, req_ff.read_y} < frame_h_ff);

   always_comb begin
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      ovf_in     = ovf_ff;
      dir_in     = dir_ff;
      map_we     = 1'b0;
      map_wdata  = DIST_UNREACHED;
      map_addr   = {y_ff[YW-1:0], x_ff};
      push_req   = 1'b0;
      q_wentry   = '{x: x_ff, y: y_ff[YW-1:0], dx: '0, dy: '0};
      count_base = count_ff;
      tail_base  = tail_ff;

      case (cmd.op)
         DP_LOAD: begin
            if (pos0) begin
               // Start of a frame: latch its size and start afresh.
               frame_w_in = eff_w;
               frame_h_in = eff_h;
               count_base = '0;
               tail_base  = '0;
               head_in    = '0;
               done_in    = 1'b0;
               ovf_in     = 1'b0;
            end
            if (in_frame) begin
               map_we    = 1'b1;
               map_wdata = seed ? '0 : DIST_UNREACHED;
               push_req  = seed;
               if (x_last) begin
                  x_in = '0;
                  y_in = y_ff + 1'b1;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
         end
         DP_FILL: begin
            map_we = 1'b1;
            if (x_last) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         DP_PROP_BEGIN: begin
            x_in = '0;
            y_in = '0;
         end
         DP_POP: begin
            head_in  = (head_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         DP_ENTRY: begin
            dir_in = DIR_LEFT;
         end
         DP_NB_RD: begin
            map_addr = {ny_c[YW-1:0], nx_c[XW-1:0]};
         end
         DP_NB_SKIP: begin
            dir_in = dir_ff + 1'b1;
         end
         DP_NB_CMP: begin
            map_addr  = {ny_ff, nx_ff};
            map_we    = improves;
            map_wdata = val[DIST_W-1:0];
            push_req  = improves;
            q_wentry  = '{x: nx_ff, y: ny_ff, dx: ndx_ff[DELTA_W-1:0],
                          dy: ndy_ff[DELTA_W-1:0]};
            dir_in    = dir_ff + 1'b1;
         end
         DP_FIN_SAT, DP_FIN_WR: begin
            map_we    = 1'b1;
            map_wdata = (cmd.op == DP_FIN_SAT) ? DIST_W'(OUT_MAX) : DIST_W'(sq_root);
            if (cell_last) begin
               x_in    = '0;
               y_in    = '0;
               done_in = 1'b1;
            end else if ({1'b0, x_ff} == frame_w_ff - 1'b1) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         DP_RD_ISSUE: begin
            map_addr = {req_ff.read_y, req_ff.read_x};
         end
         default: ;
      endcase

      // A full queue still keeps the stored value but drops the entry.
      push_ok = push_req && (count_base < QC_W'(QUEUE_DEPTH));
      if (push_req && !push_ok) begin
         ovf_in = 1'b1;
      end
      if (cmd.op == DP_LOAD || cmd.op == DP_NB_CMP) begin
         count_in = push_ok ? count_base + 1'b1 : count_base;
         if (push_ok) begin
            tail_in = (tail_base == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail_base + 1'b1;
         end else begin
            tail_in = tail_base;
         end
      end
      q_we = push_ok;
   end

   always_comb begin
      rsp_in.distance = (req_ff.op == OP_READ && done_ff && read_inside)
                        ? map_rdata[OUT_W-1:0] : '0;
      rsp_in.done_res = done_in;
      rsp_in.overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff   <= '0;
         frame_h_ff   <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         dir_ff       <= DIR_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_w_ff   <= frame_w_in;
         frame_h_ff   <= frame_h_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.op == DP_CAPTURE) begin
         req_ff <= req_item;
      end
      if (cmd.op == DP_ENTRY) begin
         ent_ff <= qentry_type'(q_rdata);
      end
      if (cmd.op == DP_NB_RD) begin
         nx_ff  <= nx_c[XW-1:0];
         ny_ff  <= ny_c[YW-1:0];
         ndx_ff <= ndx_c;
         ndy_ff <= ndy_c;
         sqx_ff <= ndx_c * ndx_c;
         sqy_ff <= ndy_c * ndy_c;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   edm_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAP_DEPTH)
   ) u_dist_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_addr),
      .wdata (map_wdata),
      .raddr (map_addr),
      .rdata (map_rdata)
   );

   edm_ram #(
      .WIDTH (QENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (tail_base),
      .wdata (QENTRY_W'(q_wentry)),
      .raddr (head_ff),
      .rdata (q_rdata)
   );

   edm_isqrt #(
      .IN_W (SQ_IN_W)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .load    (cmd.op == DP_SQRT_LOAD),
      .operand (SQ_IN_W'(map_rdata) << (2 * PRECISION_SHIFT)),
      .done    (sq_done),
      .root    (sq_root)
   );

   always_comb begin
      status.req_last     = req_ff.last_pixel;
      status.pos_in_frame = (y_ff < frame_h_ff);
      status.queue_empty  = (count_ff == '0);
      status.nb_inside    = nb_inside;
      status.dir_last     = (dir_ff == DIR_DOWN);
      status.cell_last    = cell_last;
      status.unreached    = (map_rdata == DIST_UNREACHED);
      status.sqrt_done    = sq_done;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with head and tail apart");

   a_dist_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.distance != '0 |-> rsp_ff.done_res)
      else $error("distance returned before the frame is done");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_POP |-> count_ff != '0)
      else $error("pop from an empty queue");
`endif

endmodule

### dv/euclidean_distance_map_top_test.sv
// Self-checking testbench for euclidean_distance_map_top: pixel loads, frame
// computation and distance reads are checked against an in-bench predictor.
// Depends on edm_pkg and the euclidean_distance_map_top RTL.
`timescale 1ns / 1ps

module euclidean_distance_map_top_test;
   import edm_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int FRAME_QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   localparam int UNREACHED = 131071;

   typedef struct {
      int x;
      int y;
      int dx;
      int dy;
   } wave_entry;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [DIM_W-1:0]     csr_wdata = '0;

   euclidean_distance_map_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   int        dist_cells[MAP_DEPTH];
   wave_entry wavefront[$];
   int        width_reg = 256, height_reg = 256, threshold_reg = 128;
   int        frame_w = 0, frame_h = 0, load_pos = 0;
   bit        frame_done = 0, queue_overflow = 0;

   rsp_type   distances_due[$];
   int        failures = 0;
   int        cycles = 0;
   int        items_sent = 0;
   bit        calm = 0;

   function automatic int clamp_size(int v);
      if (v == 0) return 1;
      return (v > 256) ? 256 : v;
   endfunction

   function automatic int int_sqrt(longint v);
      longint r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return int'(r);
   endfunction

   function automatic void enqueue_wave(int x, int y, int dx, int dy);
      wave_entry e;
      if (wavefront.size() >= FRAME_QUEUE_DEPTH) begin
         queue_overflow = 1;
         return;
      end
      e.x = x; e.y = y; e.dx = dx; e.dy = dy;
      wavefront.insert(wavefront.size(), e);
   endfunction

   function automatic void propagate_frame();
      int sx[4] = '{-1, 0, 1, 0};
      int sy[4] = '{0, -1, 0, 1};
      wave_entry e;
      int nx, ny, ndx, ndy, val, idx, r;
      while (wavefront.size() > 0) begin
         e = wavefront.pop_front();
         for (int d = 0; d < 4; d++) begin
            nx = e.x + sx[d];
            ny = e.y + sy[d];
            ndx = e.dx + sx[d];
            ndy = e.dy + sy[d];
            if (nx < 0 || ny < 0 || nx >= frame_w || ny >= frame_h) continue;
            val = ndx * ndx + ndy * ndy;
            idx = ny * MAX_WIDTH + nx;
            if (val >= dist_cells[idx]) continue;
            dist_cells[idx] = val;
            enqueue_wave(nx, ny, ndx, ndy);
         end
      end
      for (int y = 0; y < frame_h; y++) begin
         for (int x = 0; x < frame_w; x++) begin
            idx = y * MAX_WIDTH + x;
            if (dist_cells[idx] >= UNREACHED) begin
               r = 65535;
            end else begin
               r = int_sqrt(longint'(dist_cells[idx]) << (2 * DEF_PRECISION_SHIFT));
               if (r > 65535) r = 65535;
            end
            dist_cells[idx] = r;
         end
      end
      frame_done = 1;
   endfunction

   function automatic rsp_type predict_distance(req_type r);
      rsp_type o;
      int x, y;
      o.distance = '0;
      if (r.op == OP_LOAD) begin
         if (load_pos == 0) begin
            frame_w = clamp_size(width_reg);
            frame_h = clamp_size(height_reg);
            foreach (dist_cells[i]) dist_cells[i] = UNREACHED;
            wavefront.delete();
            frame_done = 0;
            queue_overflow = 0;
         end
         if (load_pos < frame_w * frame_h) begin
            x = load_pos % frame_w;
            y = load_pos / frame_w;
            if (int'(r.luminance) < threshold_reg) begin
               dist_cells[y * MAX_WIDTH + x] = 0;
               enqueue_wave(x, y, 0, 0);
            end
            load_pos++;
         end
         if (r.last_pixel) begin
            propagate_frame();
            load_pos = 0;
         end
      end else if (frame_done && int'(r.read_x) < frame_w && int'(r.read_y) < frame_h) begin
         o.distance = 16'(dist_cells[int'(r.read_y) * MAX_WIDTH + int'(r.read_x)]);
      end
      o.done_res = frame_done;
      o.overflow = queue_overflow;
      return o;
   endfunction

   task automatic send_req(req_type r);
      if (!calm && $urandom_range(99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      distances_due.insert(distances_due.size(), predict_distance(r));
      items_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (distances_due.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg = value & 9'h1FF;
         CSR_IMAGE_HEIGHT: height_reg = value & 9'h1FF;
         CSR_FG_THRESHOLD: threshold_reg = value & 9'h1FF;
         default: ;
      endcase
   endtask

   task automatic load_pixel(int lum, bit last);
      req_type r;
      r = '0;
      r.op = OP_LOAD;
      r.luminance = 8'(lum);
      r.last_pixel = last;
      r.read_x = 8'($urandom);
      r.read_y = 8'($urandom);
      send_req(r);
   endtask

   task automatic read_at(int x, int y);
      req_type r;
      r = '0;
      r.op = OP_READ;
      r.luminance = 8'($urandom);
      r.last_pixel = 1'($urandom);
      r.read_x = 8'(x);
      r.read_y = 8'(y);
      send_req(r);
   endtask

   task automatic test_read_before_frame();
      read_at(0, 0);
      read_at(255, 255);
   endtask

   // Zero sizes act as one; a single pixel below the threshold gives distance zero.
   task automatic test_single_cell();
      write_reg(CSR_IMAGE_WIDTH, 0);
      write_reg(CSR_IMAGE_HEIGHT, 0);
      write_reg(CSR_FG_THRESHOLD, 256);
      load_pixel(255, 0);
      load_pixel(0, 1);
      read_at(0, 0);
      read_at(1, 0);
   endtask

   // Oversized width saturates; a short frame fills its unloaded tail, which the seeds then reach.
   task automatic test_short_wide_frame();
      write_reg(CSR_IMAGE_WIDTH, 511);
      write_reg(CSR_IMAGE_HEIGHT, 1);
      load_pixel(0, 0);
      read_at(0, 0);
      load_pixel(200, 0);
      write_reg(CSR_IMAGE_HEIGHT, 511);
      load_pixel(255, 1);
      read_at(2, 0);
      read_at(255, 0);
      read_at(0, 1);
   endtask

   // Without seeds every cell saturates; tall frame checks height clamping.
   task automatic test_no_seeds_tall();
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_FG_THRESHOLD, 0);
      load_pixel(0, 0);
      load_pixel(0, 1);
      read_at(0, 1);
      read_at(0, 255);
   endtask

   // Loads past the end of a frame are dropped but last_pixel still counts.
   task automatic test_surplus_pixels();
      write_reg(CSR_IMAGE_WIDTH, 2);
      write_reg(CSR_IMAGE_HEIGHT, 2);
      write_reg(CSR_FG_THRESHOLD, 10);
      for (int i = 0; i < 6; i++) load_pixel(i == 3 ? 5 : 100, i == 5);
      read_at(0, 0);
      read_at(1, 1);
   endtask

   task automatic test_random_frames();
      int w, h, n, extra, reads;
      while (items_sent < 760) begin
         calm = (items_sent >= 300 && items_sent < 420);
         if ($urandom_range(9) == 0) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 4);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
         end
         write_reg(CSR_IMAGE_WIDTH, w);
         write_reg(CSR_IMAGE_HEIGHT, h);
         if ($urandom_range(2) == 0)
            write_reg(CSR_FG_THRESHOLD, $urandom_range(0, 256));
         n = w * h;
         extra = 0;
         case ($urandom_range(9))
            0: n = $urandom_range(1, n);
            1: extra = $urandom_range(1, 3);
            default: ;
         endcase
         for (int i = 0; i < n + extra; i++) begin
            if ($urandom_range(19) == 0) read_at($urandom_range(0, 15), $urandom_range(0, 15));
            load_pixel($urandom_range(0, 255), i == n + extra - 1);
         end
         reads = $urandom_range(3, 10);
         for (int i = 0; i < reads; i++) begin
            if ($urandom_range(7) == 0)
               read_at($urandom_range(0, 255), $urandom_range(0, 255));
            else
               read_at($urandom_range(0, w - 1), $urandom_range(0, h - 1));
         end
         if (items_sent > 600 && items_sent < 640) drain_results();
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (distances_due.size() == 0) begin
            $error("unexpected result: distance %0d", rsp_item.distance);
            failures++;
         end else begin
            want = distances_due.pop_front();
            if (rsp_item.distance !== want.distance) begin
               $error("distance: expected %0d, got %0d", want.distance, rsp_item.distance);
               failures++;
            end
            if (rsp_item.done_res !== want.done_res) begin
               $error("done_res: expected %0d, got %0d", want.done_res, rsp_item.done_res);
               failures++;
            end
            if (rsp_item.overflow !== want.overflow) begin
               $error("overflow: expected %0d, got %0d", want.overflow, rsp_item.overflow);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_read_before_frame();
      test_single_cell();
      test_short_wide_frame();
      test_no_seeds_tall();
      test_surplus_pixels();
      test_random_frames();
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
